// ===== rtl/arpnc_pkg.sv =====
// Shared types and constants for the ARP neighbor cache and responder.
// No dependencies; arpnc_ctrl, arpnc_dp and the top level import this package.
package arpnc_pkg;

	localparam int IP_W  = 32;
	localparam int MAC_W = 48;
	localparam int OP_W  = 16;
	localparam int ENT_W = IP_W + MAC_W;

	localparam logic [IP_W-1:0]  OWN_IP_RST  = 32'h0A00_020F;
	localparam logic [MAC_W-1:0] OWN_MAC_RST = 48'h5254_0012_3456;

	localparam logic [OP_W-1:0] OP_REQUEST = 16'd1;

	localparam logic REQ_ARP    = 1'b0;
	localparam logic REQ_LOOKUP = 1'b1;

	localparam logic CFG_OWN_IP  = 1'b0;
	localparam logic CFG_OWN_MAC = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic scan_done;
	} ctrl_sts_t;

endpackage

// ===== rtl/arpnc_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module arpnc_ram #(
	parameter int WIDTH = 80,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/arpnc_ctrl.sv =====
// Controller state machine for the ARP neighbor cache: accept, scan, commit.
// Depends on arpnc_pkg for the state, command and status types.
module arpnc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	output logic                  out_valid,
	input  logic                  out_stall,
	input  arpnc_pkg::ctrl_sts_t  sts,
	output arpnc_pkg::ctrl_cmd_t  cmd
);
	import arpnc_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   out_free;

	assign out_free   = !out_valid_q || !out_stall;
	assign in_stall   = (state_q != ST_IDLE);
	assign out_valid  = out_valid_q;
	assign cmd.load   = (state_q == ST_IDLE) && in_valid;
	assign cmd.scan   = (state_q == ST_SCAN);
	assign cmd.commit = (state_q == ST_FINISH) && out_free;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_SCAN;
			end
			ST_SCAN: begin
				if (sts.scan_done) state_nxt = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/arpnc_dp.sv =====
// Datapath of the ARP neighbor cache: item registers, configuration registers,
// valid bits, entry RAM scan pipeline and result registers.
// Depends on arpnc_pkg and arpnc_ram.
module arpnc_dp #(
	parameter int CACHE_ENTRIES = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  arpnc_pkg::ctrl_cmd_t         cmd,
	output arpnc_pkg::ctrl_sts_t         sts,
	input  logic                         cfg_valid,
	input  logic                         cfg_index,
	input  logic [arpnc_pkg::MAC_W-1:0]  cfg_data,
	input  logic                         req_type,
	input  logic [arpnc_pkg::OP_W-1:0]   arp_opcode,
	input  logic [arpnc_pkg::IP_W-1:0]   peer_ip,
	input  logic [arpnc_pkg::MAC_W-1:0]  peer_mac,
	input  logic [arpnc_pkg::IP_W-1:0]   asked_ip,
	output logic                         learned,
	output logic                         cache_full,
	output logic                         send_reply,
	output logic [arpnc_pkg::MAC_W-1:0]  reply_mac,
	output logic [arpnc_pkg::IP_W-1:0]   reply_ip,
	output logic                         lookup_hit,
	output logic [arpnc_pkg::MAC_W-1:0]  lookup_mac
);
	import arpnc_pkg::*;

	localparam int IW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
	localparam logic [IW-1:0] LAST = IW'(CACHE_ENTRIES - 1);

	logic [IP_W-1:0]          own_ip_q;
	logic [MAC_W-1:0]         own_mac_q;
	logic [CACHE_ENTRIES-1:0] valid_q;

	logic             type_q;
	logic [OP_W-1:0]  op_q;
	logic [IP_W-1:0]  ip_q;
	logic [MAC_W-1:0] mac_q;
	logic [IP_W-1:0]  asked_q;

	logic [IW-1:0]    idx_q;
	logic             issuing_q;
	logic             chk_s1;
	logic [IW-1:0]    chk_idx_s1;
	logic             found_q;
	logic [IW-1:0]    found_idx_q;
	logic [MAC_W-1:0] found_mac_q;

	logic [ENT_W-1:0] rd_data;
	logic             ent_valid;
	logic             ip_match;
	logic             take;
	logic             is_arp;
	logic             do_reply;
	logic             do_write;

	assign is_arp    = (type_q == REQ_ARP);
	assign ent_valid = valid_q[chk_idx_s1];
	assign ip_match  = (rd_data[ENT_W-1:MAC_W] == ip_q);
	assign take      = is_arp ? (!ent_valid || ip_match) : (ent_valid && ip_match);
	assign sts.scan_done = chk_s1 && (take || (chk_idx_s1 == LAST));
	assign do_reply  = is_arp && (op_q == OP_REQUEST) && (asked_q == own_ip_q);
	assign do_write  = cmd.commit && is_arp && found_q;

	arpnc_ram #(
		.WIDTH(ENT_W),
		.DEPTH(CACHE_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (do_write),
		.waddr (found_idx_q),
		.wdata ({ip_q, mac_q}),
		.raddr (idx_q),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_ip_q  <= OWN_IP_RST;
			own_mac_q <= OWN_MAC_RST;
			valid_q   <= '0;
			issuing_q <= 1'b0;
			chk_s1    <= 1'b0;
			found_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_OWN_IP:  own_ip_q  <= cfg_data[IP_W-1:0];
					CFG_OWN_MAC: own_mac_q <= cfg_data;
					default:     own_ip_q  <= own_ip_q;
				endcase
			end
			if (cmd.load) begin
				issuing_q <= 1'b1;
				chk_s1    <= 1'b0;
				found_q   <= 1'b0;
			end else begin
				chk_s1 <= cmd.scan && issuing_q;
				if (cmd.scan && (idx_q == LAST)) issuing_q <= 1'b0;
				if (cmd.scan && chk_s1 && take) found_q <= 1'b1;
			end
			if (do_write) valid_q[found_idx_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			type_q  <= req_type;
			op_q    <= arp_opcode;
			ip_q    <= peer_ip;
			mac_q   <= peer_mac;
			asked_q <= asked_ip;
			idx_q   <= '0;
		end else if (cmd.scan && issuing_q && (idx_q != LAST)) begin
			idx_q <= idx_q + IW'(1);
		end
		chk_idx_s1 <= idx_q;
		if (cmd.scan && chk_s1 && take && !found_q) begin
			found_idx_q <= chk_idx_s1;
			found_mac_q <= rd_data[MAC_W-1:0];
		end
		if (cmd.commit) begin
			learned    <= is_arp && found_q;
			cache_full <= is_arp && !found_q;
			send_reply <= do_reply;
			reply_mac  <= do_reply ? mac_q : '0;
			reply_ip   <= do_reply ? ip_q : '0;
			lookup_hit <= !is_arp && found_q;
			lookup_mac <= (!is_arp && found_q) ? found_mac_q : '0;
		end
	end

endmodule

// ===== rtl/arp_responder_neighbor_cache_unit.sv =====
// Top level of the ARP neighbor cache and responder.
// Depends on arpnc_pkg, arpnc_ctrl, arpnc_dp and arpnc_ram.
//
//   channel  handshake            payload
//   in       in_valid / in_stall  req_type arp_opcode peer_ip peer_mac asked_ip
//   out      out_valid/out_stall  learned cache_full send_reply reply_mac reply_ip
//                                 lookup_hit lookup_mac
//   cfg      cfg_valid/cfg_ready  cfg_index cfg_data
//
// The time from one acceptance to the next is set by the single read port of the entry RAM,
// which is scanned one entry per cycle; the next item is accepted only in the idle state.
// The scan stops at the first usable entry or at the last entry.
// Reset clears all valid bits at once and restores both station addresses.
// A new item is taken while a result waits; the block holds in the commit state
// only when the previous result has not yet been taken.
module arp_responder_neighbor_cache_unit #(
	parameter int CACHE_ENTRIES = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         req_type,
	input  logic [arpnc_pkg::OP_W-1:0]   arp_opcode,
	input  logic [arpnc_pkg::IP_W-1:0]   peer_ip,
	input  logic [arpnc_pkg::MAC_W-1:0]  peer_mac,
	input  logic [arpnc_pkg::IP_W-1:0]   asked_ip,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         learned,
	output logic                         cache_full,
	output logic                         send_reply,
	output logic [arpnc_pkg::MAC_W-1:0]  reply_mac,
	output logic [arpnc_pkg::IP_W-1:0]   reply_ip,
	output logic                         lookup_hit,
	output logic [arpnc_pkg::MAC_W-1:0]  lookup_mac,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic                         cfg_index,
	input  logic [arpnc_pkg::MAC_W-1:0]  cfg_data
);
	import arpnc_pkg::*;

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	assign cfg_ready = 1'b1;

	arpnc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	arpnc_dp #(
		.CACHE_ENTRIES(CACHE_ENTRIES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.req_type   (req_type),
		.arp_opcode (arp_opcode),
		.peer_ip    (peer_ip),
		.peer_mac   (peer_mac),
		.asked_ip   (asked_ip),
		.learned    (learned),
		.cache_full (cache_full),
		.send_reply (send_reply),
		.reply_mac  (reply_mac),
		.reply_ip   (reply_ip),
		.lookup_hit (lookup_hit),
		.lookup_mac (lookup_mac)
	);

endmodule
